### rtl/mig_pkg.sv
// ----------------------------------------------------------------------------
// mig_pkg
// shared types, constants and saturation helper of the matrix inverter
// ----------------------------------------------------------------------------
package mig_pkg;

    localparam int DATA_W      = 32;
    localparam int MAX_DIM_DEF = 8;
    localparam int SIZE_W      = 4;
    localparam int SIZE_RESET  = 8;

    typedef logic signed [DATA_W-1:0] t_word;

    localparam t_word Q_ONE    = 32'sh0001_0000;
    localparam t_word WORD_MAX = 32'sh7FFF_FFFF;
    localparam t_word WORD_MIN = 32'sh8000_0000;

    // clamp a 49-bit signed sum to the signed 32-bit range
    function automatic t_word sat_q(input logic signed [48:0] v);
        t_word r;
        if (!v[48] && (v[47:31] != '0)) begin
            r = WORD_MAX;
        end else if (v[48] && (v[47:31] != '1)) begin
            r = WORD_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### rtl/matrix_inverse_gauss_jordan_unit.sv
// ----------------------------------------------------------------------------
// matrix_inverse_gauss_jordan_unit
// gauss-jordan inverter for up to MAX_DIM x MAX_DIM q16.16 matrices
// ----------------------------------------------------------------------------
//
// channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+--------------------------
// entry     | in        | start & !busy             | i_entry_value
// config    | in        | i_cfg_valid & o_cfg_ready | i_cfg_data (matrix size)
// result    | out       | o_result_valid strobe     | o_inverse_value, o_singular,
//           |           |                           | o_last
//
// - loading accepts a request whenever busy is low; busy stays low until the last
//   entry, except while a size write is offered, which wins over an entry
// - then an identity fill of the inverse matrix, then the inversion
// - each row element passes S_ERD, S_EX1 and S_EWR for an add step, adds S_EX2
//   and S_EX3 for a multiply-update step and waits in S_EX2 for a divide step
//   (bit-serial divider, one quotient bit a cycle)
// - both matrices live in one ram with one write port, which sets the pace
// - each result follows its own ram read (S_ORD, then S_OWT); no stall from receiver
// - synchronous active-low reset; ram contents are not cleared
//
module matrix_inverse_gauss_jordan_unit #(
    parameter int MAX_DIM = mig_pkg::MAX_DIM_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  mig_pkg::t_word                i_entry_value,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mig_pkg::SIZE_W-1:0]    i_cfg_data,
    output logic                          o_result_valid,
    output mig_pkg::t_word                o_inverse_value,
    output logic                          o_singular,
    output logic                          o_last
);
    import mig_pkg::*;

    localparam int RW     = $clog2(MAX_DIM);      // row / column index bits
    localparam int CW     = $clog2(MAX_DIM + 1);  // counter bits, can hold n
    localparam int ADDR_W = 1 + 2 * RW;           // {matrix, row, col}

    typedef enum logic [4:0] {
        S_LOAD, S_INIT, S_PRD, S_PCHK, S_SRD, S_SCHK, S_KRD, S_KCHK,
        S_ERD, S_EX1, S_EX2, S_EX3, S_EWR, S_NEXT, S_FWD, S_BWD, S_ORD, S_OWT
    } t_state;

    typedef enum logic [1:0] {OP_ADD, OP_DIV, OP_UPD} t_op;
    typedef enum logic [1:0] {PH_REP, PH_DIV, PH_FWD, PH_BWD} t_phase;

    localparam logic MAT_W = 1'b0;  // working matrix
    localparam logic MAT_V = 1'b1;  // inverse being built

    t_state             r_state;
    t_op                r_op;
    t_phase             r_phase;
    logic [SIZE_W-1:0]  r_size;
    logic [CW-1:0]      r_lrow, r_lcol;
    logic [2*RW-1:0]    r_sweep;
    logic [CW-1:0]      r_i, r_j, r_c;
    logic [CW-1:0]      r_dst, r_src;
    logic [CW-1:0]      r_orow, r_ocol;
    logic               r_mat;
    logic               r_second;
    logic               r_repaired;
    logic               r_sing;
    logic               r_out_valid;
    logic               r_out_last;
    logic               r_out_sing;
    t_word              r_out_value;
    t_word              r_piv;
    t_word              r_y;
    t_word              r_res;
    logic signed [32:0] r_k;
    logic signed [63:0] r_prod;
    logic signed [47:0] r_p;

    logic [CW-1:0]      w_n, w_nm1;
    logic               w_in_acc;
    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr, w_raddr_a, w_raddr_b;
    t_word              w_wdata, w_rdata_a, w_rdata_b;
    logic               w_div_start, w_div_done;
    t_word              w_div_quot;
    logic signed [32:0] w_x33;
    logic signed [65:0] w_prod;
    logic signed [63:0] w_pb;
    logic signed [48:0] w_add_sum, w_upd_sum;

    // size in use: zero acts as one, large values clamp to MAX_DIM
    always_comb begin
        if (r_size == '0) begin
            w_n = CW'(1);
        end else if (int'(r_size) > MAX_DIM) begin
            w_n = CW'(MAX_DIM);
        end else begin
            w_n = CW'(r_size);
        end
    end
    assign w_nm1 = w_n - 1'b1;

    // a pending size write holds off entries so none is taken and dropped
    assign busy        = (r_state != S_LOAD) || i_cfg_valid;
    assign o_cfg_ready = (r_state == S_LOAD);
    assign w_in_acc    = start && !busy;

    // arithmetic of one row element
    assign w_x33     = {w_rdata_b[DATA_W-1], w_rdata_b};
    assign w_prod    = r_k * w_x33;
    assign w_pb      = r_prod + (r_prod[63] ? 64'sd65535 : 64'sd0);
    assign w_add_sum = {{17{w_rdata_a[31]}}, w_rdata_a} + {{17{w_rdata_b[31]}}, w_rdata_b};
    assign w_upd_sum = {{17{r_y[31]}}, r_y} + {r_p[47], r_p};

    assign w_div_start = (r_state == S_EX1) && (r_op == OP_DIV);

    // ram write port
    always_comb begin
        w_we    = 1'b0;
        w_waddr = {r_mat, r_dst[RW-1:0], r_c[RW-1:0]};
        w_wdata = r_res;
        unique case (r_state)
            S_LOAD: begin
                w_we    = w_in_acc;
                w_waddr = {MAT_W, r_lrow[RW-1:0], r_lcol[RW-1:0]};
                w_wdata = i_entry_value;
            end
            S_INIT: begin
                w_we    = 1'b1;
                w_waddr = {MAT_V, r_sweep};
                w_wdata = (r_sweep[2*RW-1:RW] == r_sweep[RW-1:0]) ? Q_ONE : '0;
            end
            S_EWR: begin
                w_we = 1'b1;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // ram read ports
    always_comb begin
        w_raddr_b = {r_mat, r_src[RW-1:0], r_c[RW-1:0]};
        unique case (r_state)
            S_PRD:          w_raddr_a = {MAT_W, r_i[RW-1:0], r_i[RW-1:0]};
            S_SRD, S_KRD:   w_raddr_a = {MAT_W, r_j[RW-1:0], r_i[RW-1:0]};
            S_ORD:          w_raddr_a = {MAT_V, r_orow[RW-1:0], r_ocol[RW-1:0]};
            default:        w_raddr_a = {r_mat, r_dst[RW-1:0], r_c[RW-1:0]};
        endcase
    end

    mig_ram #(
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    mig_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_rdata_a),
        .i_den   (r_piv),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_size      <= SIZE_W'(SIZE_RESET);
            r_lrow      <= '0;
            r_lcol      <= '0;
            r_sing      <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
            r_out_sing  <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            unique case (r_state)
                S_LOAD: begin
                    if (i_cfg_valid) begin
                        // a size write restarts the load
                        r_size <= i_cfg_data;
                        r_lrow <= '0;
                        r_lcol <= '0;
                    end else if (w_in_acc) begin
                        if (r_lcol == w_nm1) begin
                            r_lcol <= '0;
                            if (r_lrow == w_nm1) begin
                                r_lrow  <= '0;
                                r_sweep <= '0;
                                r_sing  <= 1'b0;
                                r_state <= S_INIT;
                            end else begin
                                r_lrow <= r_lrow + 1'b1;
                            end
                        end else begin
                            r_lcol <= r_lcol + 1'b1;
                        end
                    end
                end
                S_INIT: begin
                    // identity fill of the inverse half
                    r_sweep <= r_sweep + 1'b1;
                    if (r_sweep == '1) begin
                        r_i        <= '0;
                        r_repaired <= 1'b0;
                        r_state    <= S_PRD;
                    end
                end
                S_PRD: begin
                    r_state <= S_PCHK;
                end
                S_PCHK: begin
                    if (w_rdata_a != '0) begin
                        // divide inverse row first, then working row
                        r_piv    <= w_rdata_a;
                        r_op     <= OP_DIV;
                        r_phase  <= PH_DIV;
                        r_mat    <= MAT_V;
                        r_second <= 1'b0;
                        r_dst    <= r_i;
                        r_c      <= '0;
                        r_state  <= S_ERD;
                    end else if (r_repaired) begin
                        r_sing  <= 1'b1;
                        r_orow  <= '0;
                        r_ocol  <= '0;
                        r_state <= S_ORD;
                    end else begin
                        r_j     <= r_i + 1'b1;
                        r_state <= S_SRD;
                    end
                end
                S_SRD: begin
                    // search the column below the pivot
                    if (r_j >= w_n) begin
                        r_sing  <= 1'b1;
                        r_orow  <= '0;
                        r_ocol  <= '0;
                        r_state <= S_ORD;
                    end else begin
                        r_state <= S_SCHK;
                    end
                end
                S_SCHK: begin
                    if (w_rdata_a != '0) begin
                        r_op       <= OP_ADD;
                        r_phase    <= PH_REP;
                        r_mat      <= MAT_W;
                        r_second   <= 1'b0;
                        r_dst      <= r_i;
                        r_src      <= r_j;
                        r_c        <= '0;
                        r_repaired <= 1'b1;
                        r_state    <= S_ERD;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_SRD;
                    end
                end
                S_KRD: begin
                    r_state <= S_KCHK;
                end
                S_KCHK: begin
                    // factor taken before row j changes
                    r_k      <= -{w_rdata_a[DATA_W-1], w_rdata_a};
                    r_op     <= OP_UPD;
                    r_mat    <= MAT_W;
                    r_second <= 1'b0;
                    r_dst    <= r_j;
                    r_src    <= r_i;
                    r_c      <= '0;
                    r_state  <= S_ERD;
                end
                S_ERD: begin
                    r_state <= S_EX1;
                end
                S_EX1: begin
                    case (r_op)
                        OP_ADD: begin
                            r_res   <= sat_q(w_add_sum);
                            r_state <= S_EWR;
                        end
                        OP_UPD: begin
                            r_prod  <= w_prod[63:0];
                            r_y     <= w_rdata_a;
                            r_state <= S_EX2;
                        end
                        default: begin
                            r_state <= S_EX2;
                        end
                    endcase
                end
                S_EX2: begin
                    if (r_op == OP_UPD) begin
                        // truncate toward zero
                        r_p     <= w_pb[63:16];
                        r_state <= S_EX3;
                    end else if (w_div_done) begin
                        r_res   <= w_div_quot;
                        r_state <= S_EWR;
                    end
                end
                S_EX3: begin
                    r_res   <= sat_q(w_upd_sum);
                    r_state <= S_EWR;
                end
                S_EWR: begin
                    r_c <= r_c + 1'b1;
                    if (r_c == w_nm1) begin
                        r_state <= S_NEXT;
                    end else begin
                        r_state <= S_ERD;
                    end
                end
                S_NEXT: begin
                    if (!r_second) begin
                        r_second <= 1'b1;
                        r_mat    <= ~r_mat;
                        r_c      <= '0;
                        r_state  <= S_ERD;
                    end else begin
                        case (r_phase)
                            PH_REP: begin
                                r_state <= S_PRD;
                            end
                            PH_DIV: begin
                                r_j     <= r_i + 1'b1;
                                r_phase <= PH_FWD;
                                r_state <= S_FWD;
                            end
                            PH_FWD: begin
                                r_j     <= r_j + 1'b1;
                                r_state <= S_FWD;
                            end
                            default: begin
                                r_state <= S_BWD;
                            end
                        endcase
                    end
                end
                S_FWD: begin
                    if (r_j < w_n) begin
                        r_state <= S_KRD;
                    end else if (r_i < w_nm1) begin
                        r_i        <= r_i + 1'b1;
                        r_repaired <= 1'b0;
                        r_state    <= S_PRD;
                    end else begin
                        r_i     <= w_nm1;
                        r_j     <= w_nm1;
                        r_phase <= PH_BWD;
                        r_state <= S_BWD;
                    end
                end
                S_BWD: begin
                    // clear entries above each pivot, last column first
                    if (r_j != '0) begin
                        r_j     <= r_j - 1'b1;
                        r_state <= S_KRD;
                    end else if (r_i != '0) begin
                        r_i <= r_i - 1'b1;
                        r_j <= r_i - 1'b1;
                    end else begin
                        r_orow  <= '0;
                        r_ocol  <= '0;
                        r_state <= S_ORD;
                    end
                end
                S_ORD: begin
                    r_state <= S_OWT;
                end
                S_OWT: begin
                    r_out_valid <= 1'b1;
                    r_out_value <= r_sing ? '0 : w_rdata_a;
                    r_out_sing  <= r_sing;
                    r_out_last  <= (r_orow == w_nm1) && (r_ocol == w_nm1);
                    if (r_ocol == w_nm1) begin
                        r_ocol <= '0;
                        r_orow <= r_orow + 1'b1;
                        if (r_orow == w_nm1) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_state <= S_ORD;
                        end
                    end else begin
                        r_ocol  <= r_ocol + 1'b1;
                        r_state <= S_ORD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_result_valid  = r_out_valid;
    assign o_inverse_value = r_out_value;
    assign o_singular      = r_out_sing;
    assign o_last          = r_out_last;

    // a result only follows an output read
    a_result_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_state == S_OWT))
        else $error("result strobe without output read");

    // singular results carry zero
    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_singular) |-> (o_inverse_value == '0))
        else $error("singular result with nonzero value");

    // divider completes only while a divide step waits for it
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> ((r_state == S_EX2) && (r_op == OP_DIV)))
        else $error("divider done outside a divide step");

    // no ram write while the inverse is being read out
    a_no_write_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> ((r_state != S_ORD) && (r_state != S_OWT)))
        else $error("ram write during output");

endmodule

### rtl/mig_ram.sv
// ----------------------------------------------------------------------------
// mig_ram
// synchronous ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module mig_ram #(
    parameter int ADDR_W = 7
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [ADDR_W-1:0]   i_waddr,
    input  mig_pkg::t_word      i_wdata,
    input  logic [ADDR_W-1:0]   i_raddr_a,
    input  logic [ADDR_W-1:0]   i_raddr_b,
    output mig_pkg::t_word      o_rdata_a,
    output mig_pkg::t_word      o_rdata_b
);
    import mig_pkg::*;

    localparam int DEPTH = 2 ** ADDR_W;

    t_word r_mem [DEPTH];
    t_word r_rdata_a;
    t_word r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

### rtl/mig_div.sv
// ----------------------------------------------------------------------------
// mig_div
// bit-serial q16.16 divider, (num * 65536) / den truncated and saturated
// ----------------------------------------------------------------------------
module mig_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  mig_pkg::t_word  i_num,
    input  mig_pkg::t_word  i_den,
    output logic            o_done,
    output mig_pkg::t_word  o_quot
);
    import mig_pkg::*;

    localparam int NUM_W = DATA_W + 16;
    localparam int CNT_W = $clog2(NUM_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [NUM_W-1:0]   r_num;
    logic [NUM_W-1:0]   r_quo;
    logic [DATA_W-1:0]  r_rem;
    logic [DATA_W-1:0]  r_den;
    logic               r_neg;

    logic [DATA_W-1:0]  w_num_abs;
    logic [DATA_W-1:0]  w_den_abs;
    logic [DATA_W:0]    w_rem_sh;
    logic [DATA_W+1:0]  w_trial;
    logic               w_fit;

    assign w_num_abs = i_num[DATA_W-1] ? (~i_num + 1'b1) : i_num;
    assign w_den_abs = i_den[DATA_W-1] ? (~i_den + 1'b1) : i_den;
    assign w_rem_sh  = {r_rem, r_num[NUM_W-1]};
    assign w_trial   = {1'b0, w_rem_sh} - {2'b00, r_den};
    assign w_fit     = !w_trial[DATA_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= {w_num_abs, 16'h0000};
                r_den  <= w_den_abs;
                r_rem  <= '0;
                r_quo  <= '0;
                r_neg  <= i_num[DATA_W-1] ^ i_den[DATA_W-1];
            end else if (r_busy) begin
                r_num <= {r_num[NUM_W-2:0], 1'b0};
                r_quo <= {r_quo[NUM_W-2:0], w_fit};
                r_rem <= w_fit ? w_trial[DATA_W-1:0] : w_rem_sh[DATA_W-1:0];
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // sign and clamp the magnitude quotient
    always_comb begin
        if (!r_neg) begin
            o_quot = (r_quo[NUM_W-1:DATA_W-1] != '0) ? WORD_MAX : r_quo[DATA_W-1:0];
        end else if ((r_quo[NUM_W-1:DATA_W] != '0) ||
                     (r_quo[DATA_W-1] && (r_quo[DATA_W-2:0] != '0))) begin
            o_quot = WORD_MIN;
        end else begin
            o_quot = ~r_quo[DATA_W-1:0] + 1'b1;
        end
    end

    assign o_done = r_done;

endmodule
